[rtl/fts_pkg.sv]
// Shared types, codes and field widths for the frame timing sequencer.
package fts_pkg;

    localparam int FUNC_W     = 2;
    localparam int SLOT_W     = 6;
    localparam int LEN_W      = 24;
    localparam int OFS_W      = 32;
    localparam int FIDX_W     = 6;
    localparam int WRAP_W     = 16;
    localparam int FCNT_W     = 7;
    localparam int SCALE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_WRITE   = 2'd1,
        FUNC_RESTART = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT = 3'd0,
        CFG_LOOPING     = 3'd1,
        CFG_REVERSE     = 3'd2,
        CFG_TIME_SCALE  = 3'd3,
        CFG_TICK_LENGTH = 3'd4
    } t_cfg_idx;

    localparam logic [FCNT_W-1:0]  RST_FRAME_COUNT = 7'd1;
    localparam logic [SCALE_W-1:0] RST_TIME_SCALE  = 16'd256;
    localparam logic [SCALE_W-1:0] RST_TICK_LENGTH = 16'd1000;

endpackage

[rtl/fts_in_if.sv]
// Input channel of the frame timing sequencer: one command per transfer.
interface fts_in_if;
    logic                          valid;
    logic                          ready;
    logic [fts_pkg::FUNC_W-1:0]    func;
    logic [fts_pkg::SLOT_W-1:0]    frame_slot;
    logic [fts_pkg::LEN_W-1:0]     frame_length;
    logic [fts_pkg::OFS_W-1:0]     start_offset;

    modport source (output valid, func, frame_slot, frame_length, start_offset, input ready);
    modport sink   (input valid, func, frame_slot, frame_length, start_offset, output ready);
endinterface

[rtl/fts_out_if.sv]
// Result channel of the frame timing sequencer: animation status per transfer.
interface fts_out_if;
    logic                          valid;
    logic                          ready;
    logic [fts_pkg::FIDX_W-1:0]    frame_index;
    logic [fts_pkg::WRAP_W-1:0]    loop_count;
    logic                          finished;

    modport source (output valid, frame_index, loop_count, finished, input ready);
    modport sink   (input valid, frame_index, loop_count, finished, output ready);
endinterface

[rtl/fts_div.sv]
// Restoring divider, one quotient bit per cycle.
module fts_div #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quot,
    output logic [DIVISOR_W-1:0]  o_rem
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_quot;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign trial = {r_rem, r_quot[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_cnt  <= CNT_W'(DIVIDEND_W);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIVIDEND_W-2:0], ge};
            r_rem  <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            r_cnt  <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

[rtl/frame_timing_sequencer.sv]
// Frame timing sequencer: duration table in a synchronous RAM plus a tick sequencer.
// Throughput: one command at a time; the next is taken once the previous result is queued.
// Sequence: write, restart and no-op commands, and a tick on a finished animation, go from idle
//   through the finish state to the result register. A tick adds the scaled tick length, then steps
//   frame by frame (one RAM read per step); looping first sweeps the durations over the n frames,
//   and runs the whole-cycle division when the accrued time exceeds one full pass.
// Reset (synchronous, active low): frame 0, time 0, no loops, not finished, registers at their
//   defaults; the duration table is not cleared and holds garbage until written.
module frame_timing_sequencer #(
    parameter int MAX_FRAMES = 64,
    parameter int TIME_BITS  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fts_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fts_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    fts_in_if.sink                            i_in,
    fts_out_if.source                         o_out
);
    localparam int IDX_W = $clog2(MAX_FRAMES);
    localparam int NF_W  = $clog2(MAX_FRAMES + 1);
    localparam int LEN_W = fts_pkg::LEN_W;
    localparam int TW    = LEN_W + IDX_W;                              // full-pass total
    localparam int AW    = ((TIME_BITS > LEN_W) ? TIME_BITS : LEN_W) + 1;
    localparam int CW    = (TIME_BITS > TW) ? TIME_BITS : TW;
    localparam int OW    = (TIME_BITS > fts_pkg::OFS_W) ? TIME_BITS : fts_pkg::OFS_W;
    localparam int QW    = ((TIME_BITS > fts_pkg::WRAP_W) ? TIME_BITS : fts_pkg::WRAP_W) + 1;
    localparam logic [TIME_BITS-1:0]      TIME_MAX = '1;
    localparam logic [fts_pkg::WRAP_W-1:0] WRAP_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_SUM,
        ST_SUM_END,
        ST_CMP,
        ST_DIV,
        ST_STEP_RD,
        ST_STEP_EX,
        ST_FIN
    } t_state;

    // Configuration registers
    logic [fts_pkg::FCNT_W-1:0]  r_frame_count;
    logic                        r_looping;
    logic                        r_reverse;
    logic [fts_pkg::SCALE_W-1:0] r_time_scale;
    logic [fts_pkg::SCALE_W-1:0] r_tick_length;

    // Animation state
    t_state                      r_state;
    logic [IDX_W-1:0]            r_cur;
    logic [TIME_BITS-1:0]        r_acc;
    logic [fts_pkg::WRAP_W-1:0]  r_wraps;
    logic                        r_done;

    // Tick working registers
    logic [LEN_W-1:0]            r_inc;
    logic [IDX_W-1:0]            r_idx;
    logic [TW-1:0]               r_total;
    logic                        r_pend;

    // Result register
    logic                        r_out_valid;
    logic [fts_pkg::FIDX_W-1:0]  r_out_frame;
    logic [fts_pkg::WRAP_W-1:0]  r_out_loops;
    logic                        r_out_fin;

    // Duration table
    logic [LEN_W-1:0]            r_mem [MAX_FRAMES];
    logic [LEN_W-1:0]            r_rd_data;
    logic [IDX_W-1:0]            rd_addr;
    logic                        mem_we;
    logic [LEN_W-1:0]            mem_wdata;

    logic                        in_xfer;
    logic [NF_W-1:0]             n_frames;
    logic [IDX_W-1:0]            n_last;
    logic [31:0]                 prod;
    logic [AW-1:0]               acc_sum;
    logic [TIME_BITS-1:0]        n_acc_sat;
    logic [LEN_W-1:0]            d_eff;
    logic                        acc_gt_d;
    logic                        acc_gt_total;
    logic                        at_end;
    logic [IDX_W-1:0]            step_nxt;
    logic [fts_pkg::WRAP_W-1:0]  n_wraps_inc;
    logic [QW-1:0]               wq_sum;
    logic [fts_pkg::WRAP_W-1:0]  n_wraps_div;
    logic [TIME_BITS-1:0]        n_acc_ofs;
    logic                        slot_ok;
    logic                        div_start;
    logic                        div_done;
    logic [TIME_BITS-1:0]        div_quot;
    logic [TW-1:0]               div_rem;

    // ---------------------------------------------------------------------
    // Configuration writes; indexes past the last register are dropped.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= fts_pkg::RST_FRAME_COUNT;
            r_looping     <= 1'b0;
            r_reverse     <= 1'b0;
            r_time_scale  <= fts_pkg::RST_TIME_SCALE;
            r_tick_length <= fts_pkg::RST_TICK_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fts_pkg::CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[fts_pkg::FCNT_W-1:0];
                fts_pkg::CFG_LOOPING:     r_looping     <= i_cfg_data[0];
                fts_pkg::CFG_REVERSE:     r_reverse     <= i_cfg_data[0];
                fts_pkg::CFG_TIME_SCALE:  r_time_scale  <= i_cfg_data;
                fts_pkg::CFG_TICK_LENGTH: r_tick_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------------
    assign in_xfer    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // Frames in use: zero counts as one, anything above the table size clamps to it.
    always_comb begin
        if (r_frame_count == '0) begin
            n_frames = NF_W'(1);
        end else if (32'(r_frame_count) > MAX_FRAMES) begin
            n_frames = NF_W'(MAX_FRAMES);
        end else begin
            n_frames = NF_W'(r_frame_count);
        end
    end
    assign n_last = IDX_W'(n_frames - NF_W'(1));

    // Scaled tick length: Q8.8 time scale times tick length, truncated; registered before the add.
    assign prod      = 32'(r_time_scale) * 32'(r_tick_length);
    assign acc_sum   = AW'(r_acc) + AW'(r_inc);
    assign n_acc_sat = (acc_sum > AW'(TIME_MAX)) ? TIME_MAX : acc_sum[TIME_BITS-1:0];

    // A zero entry only comes from a never-written slot; treat it as one unit.
    assign d_eff        = (r_rd_data == '0) ? LEN_W'(1) : r_rd_data;
    assign acc_gt_d     = (AW'(r_acc) > AW'(d_eff));
    assign acc_gt_total = (CW'(r_acc) > CW'(r_total));

    // Next frame in play direction and whether the current frame sits on the end.
    always_comb begin
        if (r_reverse) begin
            at_end   = (r_cur == '0);
            step_nxt = at_end ? n_last : r_cur - IDX_W'(1);
        end else begin
            at_end   = (r_cur == n_last);
            step_nxt = at_end ? '0 : r_cur + IDX_W'(1);
        end
    end

    assign n_wraps_inc = (r_wraps == WRAP_MAX) ? r_wraps : r_wraps + fts_pkg::WRAP_W'(1);
    assign wq_sum      = QW'(r_wraps) + QW'(div_quot);
    assign n_wraps_div = (wq_sum > QW'(WRAP_MAX)) ? WRAP_MAX : wq_sum[fts_pkg::WRAP_W-1:0];

    assign n_acc_ofs = (OW'(i_in.start_offset) > OW'(TIME_MAX)) ?
                       TIME_MAX : TIME_BITS'(i_in.start_offset);

    // ---------------------------------------------------------------------
    // Duration table: one write port (commands), one registered read port.
    // Writes happen only while idle, so no read can overlap a pending write.
    // ---------------------------------------------------------------------
    assign slot_ok   = (32'(i_in.frame_slot) < MAX_FRAMES);
    assign mem_we    = in_xfer && (i_in.func == fts_pkg::FUNC_WRITE) && slot_ok;
    assign mem_wdata = (i_in.frame_length == '0) ? LEN_W'(1) : i_in.frame_length;

    // Read address: sweep index while summing, current frame on the first step read,
    // and the next frame during stepping so each step needs no separate read state.
    always_comb begin
        unique case (r_state)
            ST_STEP_RD: rd_addr = r_cur;
            ST_STEP_EX: rd_addr = step_nxt;
            default:    rd_addr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[IDX_W'(i_in.frame_slot)] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // ---------------------------------------------------------------------
    // Whole-pass reduction: (acc - 1) / total gives the wraps to add, and the
    // remainder plus one is the time left inside the current pass.
    // ---------------------------------------------------------------------
    assign div_start = (r_state == ST_CMP) && acc_gt_total;

    fts_div #(
        .DIVIDEND_W (TIME_BITS),
        .DIVISOR_W  (TW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc - TIME_BITS'(1)),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= '0;
            r_acc       <= '0;
            r_wraps     <= '0;
            r_done      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result once the sink takes it; the finish state reloads it itself.
            if (r_out_valid && o_out.ready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        unique case (i_in.func)
                            fts_pkg::FUNC_TICK: begin
                                // A finished animation ignores ticks.
                                if (!r_done) begin
                                    // Frame count may have been lowered: snap to the last frame.
                                    if (NF_W'(r_cur) >= n_frames) begin
                                        r_cur <= n_last;
                                    end
                                    r_inc   <= prod[LEN_W+7:8];
                                    r_state <= ST_ADD;
                                end else begin
                                    r_state <= ST_FIN;
                                end
                            end
                            fts_pkg::FUNC_RESTART: begin
                                r_cur   <= '0;
                                r_wraps <= '0;
                                r_done  <= 1'b0;
                                r_acc   <= n_acc_ofs;
                                r_state <= ST_FIN;
                            end
                            default: r_state <= ST_FIN;  // table write goes straight to the RAM
                        endcase
                    end
                end

                ST_ADD: begin
                    r_acc   <= n_acc_sat;
                    r_idx   <= '0;
                    r_total <= '0;
                    r_pend  <= 1'b0;
                    r_state <= r_looping ? ST_SUM : ST_STEP_RD;
                end

                ST_SUM: begin
                    // Issue one read per cycle; accumulate the previous one.
                    r_idx  <= r_idx + IDX_W'(1);
                    r_pend <= 1'b1;
                    if (r_pend) begin
                        r_total <= r_total + TW'(d_eff);
                    end
                    if (NF_W'(r_idx) == NF_W'(n_last)) begin
                        r_state <= ST_SUM_END;
                    end
                end

                ST_SUM_END: begin
                    r_total <= r_total + TW'(d_eff);
                    r_pend  <= 1'b0;
                    r_state <= ST_CMP;
                end

                ST_CMP: begin
                    r_state <= acc_gt_total ? ST_DIV : ST_STEP_RD;
                end

                ST_DIV: begin
                    if (div_done) begin
                        r_acc   <= TIME_BITS'(div_rem) + TIME_BITS'(1);
                        r_wraps <= n_wraps_div;
                        r_state <= ST_STEP_RD;
                    end
                end

                ST_STEP_RD: begin
                    r_state <= ST_STEP_EX;
                end

                ST_STEP_EX: begin
                    if (acc_gt_d) begin
                        // The duration is consumed even on the finishing step.
                        r_acc <= r_acc - TIME_BITS'(d_eff);
                        if (at_end && !r_looping) begin
                            r_done  <= 1'b1;
                            r_state <= ST_FIN;
                        end else begin
                            r_cur <= step_nxt;
                            if (at_end) begin
                                r_wraps <= n_wraps_inc;
                            end
                        end
                    end else begin
                        r_state <= ST_FIN;
                    end
                end

                ST_FIN: begin
                    // Hold until the result register is free, then report the state.
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_frame <= fts_pkg::FIDX_W'(r_cur);
                        r_out_loops <= r_wraps;
                        r_out_fin   <= r_done;
                        r_state     <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.frame_index = r_out_frame;
    assign o_out.loop_count  = r_out_loops;
    assign o_out.finished    = r_out_fin;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_in.ready)
        else $error("command accepted while another is in flight");

    a_frame_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP_EX) |-> (NF_W'(r_cur) < n_frames))
        else $error("current frame outside the frames in use while stepping");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && div_done) |-> (div_rem < r_total))
        else $error("whole-pass remainder not below the pass total");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !(in_xfer && (i_in.func == fts_pkg::FUNC_RESTART))) |=> r_done)
        else $error("finished flag cleared without a restart");

endmodule
